/* hw/rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared sizes, codes and helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int RING_DEPTH = 64;
  localparam int VALUE_BITS = 16;

  // width of the capacity register as seen on the configuration port
  localparam int CAP_BITS   = 7;
  localparam int CAP_RESET  = 64;

  localparam int IDX_BITS   = $clog2(RING_DEPTH);
  localparam int CNT_BITS   = $clog2(RING_DEPTH + 1);
  localparam int CMP_BITS   = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;
  localparam int OP_BITS    = 3;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [CAP_BITS-1:0]   cap_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_NOP       = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // clamp the programmed capacity into 1 .. RING_DEPTH
  function automatic cnt_t eff_cap(input cap_t cap);
    logic [CMP_BITS-1:0] c;
    logic [CMP_BITS-1:0] d;
    cnt_t                r;
    c = CMP_BITS'(cap);
    d = CMP_BITS'(RING_DEPTH);
    if (c == '0) begin
      r = CNT_BITS'(1);
    end else if (c > d) begin
      r = CNT_BITS'(RING_DEPTH);
    end else begin
      r = CNT_BITS'(c);
    end
    return r;
  endfunction

  function automatic idx_t step_up(input idx_t idx, input cnt_t cap);
    cnt_t n;
    idx_t r;
    n = CNT_BITS'(idx) + CNT_BITS'(1);
    if (n >= cap) begin
      r = '0;
    end else begin
      r = IDX_BITS'(n);
    end
    return r;
  endfunction

  function automatic idx_t step_down(input idx_t idx, input cnt_t cap);
    cnt_t m;
    idx_t r;
    m = cap - CNT_BITS'(1);
    if (idx == '0 || CNT_BITS'(idx) >= cap) begin
      r = IDX_BITS'(m);
    end else begin
      r = idx - IDX_BITS'(1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a ring RAM with a programmable capacity.
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------
//  in       | in_op, in_item_value               | in_valid / in_ready
//  out      | out_op_ok .. out_entry_count       | out_valid / out_ready
//  cfg      | cfg_wdata                          | cfg_we, no wait
//
//  inserts, no-ops and removals that leave the deque empty register their
//  result on acceptance; a removal that exposes a new end waits in the read
//  state on the registered RAM read of that entry. a request is taken only
//  when idle and no result is pending or the pending one leaves this cycle.
//  reset (rst_n low, synchronous) empties the deque and sets capacity 64;
//  the ring RAM needs no clearing. a capacity write also empties the deque.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  cdq_pkg::cap_t           cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [cdq_pkg::OP_BITS-1:0] in_op,
  input  cdq_pkg::value_t         in_item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_op_ok,
  output cdq_pkg::value_t         out_front_value,
  output cdq_pkg::value_t         out_rear_value,
  output logic                    out_ends_valid,
  output logic                    out_is_empty,
  output logic                    out_is_full,
  output cdq_pkg::cnt_t           out_entry_count
);
  import cdq_pkg::*;

  state_t state_r, state_nxt;

  cnt_t   cap_r;
  idx_t   front_idx_r, front_idx_nxt;
  idx_t   rear_idx_r, rear_idx_nxt;
  cnt_t   cnt_r, cnt_nxt;
  value_t front_val_r, front_val_nxt;
  value_t rear_val_r, rear_val_nxt;
  logic   rd_front_r;

  logic   out_valid_r;
  logic   out_op_ok_r;
  value_t out_front_r, out_rear_r;
  logic   out_ends_r, out_empty_r, out_full_r;
  cnt_t   out_cnt_r;

  logic   accept;
  logic   ok;
  logic   need_read;
  logic   rd_front;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  value_t rd_data;
  logic   ram_we, ram_re;

  assign accept = in_valid && in_ready;

  // datapath for one request: new pointers, count, ends and ram access
  always_comb begin
    idx_t pos;
    front_idx_nxt = front_idx_r;
    rear_idx_nxt  = rear_idx_r;
    cnt_nxt       = cnt_r;
    front_val_nxt = front_val_r;
    rear_val_nxt  = rear_val_r;
    ok            = 1'b1;
    need_read     = 1'b0;
    rd_front      = 1'b0;
    rd_addr       = front_idx_r;
    wr_en         = 1'b0;
    wr_addr       = front_idx_r;
    pos           = '0;
    case (op_t'(in_op))
      OP_INS_FRONT, OP_INS_REAR: begin
        if (cnt_r >= cap_r) begin
          ok = 1'b0;
        end else if (cnt_r == '0) begin
          pos           = (op_t'(in_op) == OP_INS_FRONT) ?
                          IDX_BITS'(cap_r - CNT_BITS'(1)) : '0;
          front_idx_nxt = pos;
          rear_idx_nxt  = pos;
          front_val_nxt = in_item_value;
          rear_val_nxt  = in_item_value;
          wr_en         = 1'b1;
          wr_addr       = pos;
          cnt_nxt       = CNT_BITS'(1);
        end else if (op_t'(in_op) == OP_INS_FRONT) begin
          front_idx_nxt = step_down(front_idx_r, cap_r);
          front_val_nxt = in_item_value;
          wr_en         = 1'b1;
          wr_addr       = front_idx_nxt;
          cnt_nxt       = cnt_r + CNT_BITS'(1);
        end else begin
          rear_idx_nxt  = step_up(rear_idx_r, cap_r);
          rear_val_nxt  = in_item_value;
          wr_en         = 1'b1;
          wr_addr       = rear_idx_nxt;
          cnt_nxt       = cnt_r + CNT_BITS'(1);
        end
      end
      OP_REM_FRONT, OP_REM_REAR: begin
        if (cnt_r == '0) begin
          ok = 1'b0;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
          if (cnt_r > CNT_BITS'(1)) begin
            need_read = 1'b1;
            if (op_t'(in_op) == OP_REM_FRONT) begin
              front_idx_nxt = step_up(front_idx_r, cap_r);
              rd_front      = 1'b1;
              rd_addr       = front_idx_nxt;
            end else begin
              rear_idx_nxt  = step_down(rear_idx_r, cap_r);
              rd_addr       = rear_idx_nxt;
            end
          end
        end
      end
      default: begin
        // no-op and unused codes
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && need_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        ram_we   = accept && wr_en;
        ram_re   = accept && need_read;
      end
      S_READ: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  cdq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (in_item_value),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= eff_cap(CAP_BITS'(CAP_RESET));
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r       <= eff_cap(cfg_wdata);
        front_idx_r <= '0;
        rear_idx_r  <= '0;
        cnt_r       <= '0;
      end else if (accept) begin
        front_idx_r <= front_idx_nxt;
        rear_idx_r  <= rear_idx_nxt;
        cnt_r       <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= !need_read;
      end else if (state_r == S_READ) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // end values and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      front_val_r <= front_val_nxt;
      rear_val_r  <= rear_val_nxt;
      rd_front_r  <= rd_front;
      out_op_ok_r <= ok;
      out_ends_r  <= (cnt_nxt != '0);
      out_empty_r <= (cnt_nxt == '0);
      out_full_r  <= (cnt_nxt == cap_r);
      out_cnt_r   <= cnt_nxt;
      out_front_r <= (cnt_nxt != '0) ? front_val_nxt : '0;
      out_rear_r  <= (cnt_nxt != '0) ? rear_val_nxt : '0;
    end else if (state_r == S_READ) begin
      // new end arrives from the ram
      if (rd_front_r) begin
        front_val_r <= rd_data;
        out_front_r <= rd_data;
      end else begin
        rear_val_r  <= rd_data;
        out_rear_r  <= rd_data;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_op_ok       = out_op_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_ends_valid  = out_ends_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;
  assign out_entry_count = out_cnt_r;

endmodule
